### rtl/acpu_pkg.sv
// Shared types, opcodes and constants for the accumulator CPU execute stage.
package acpu_pkg;

   localparam int WORD_BITS   = 16;
   localparam int ADDR_BITS   = 12;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef enum logic [3:0] {
      OP_NOP      = 4'd0,
      OP_LOAD     = 4'd1,
      OP_STORE    = 4'd2,
      OP_ADD      = 4'd3,
      OP_SUBT     = 4'd4,
      OP_IN       = 4'd5,
      OP_OUT      = 4'd6,
      OP_HALT     = 4'd7,
      OP_SKIPCOND = 4'd8,
      OP_JUMP     = 4'd9,
      OP_CLEAR    = 4'd10,
      OP_ADDI     = 4'd11,
      OP_JUMPI    = 4'd12,
      OP_LOADI    = 4'd13,
      OP_STOREI   = 4'd14,
      OP_SUBTI    = 4'd15
   } opcode_type;

   // skipcond selectors
   localparam addr_type SKIP_NEG  = 12'h000;
   localparam addr_type SKIP_ZERO = 12'h400;
   localparam addr_type SKIP_POS  = 12'h800;

   typedef struct packed {
      opcode_type opcode;
      addr_type   address;
      word_type   in_value;
      logic       rd_ptr;
      logic       rd_data;
      logic       wr_mem;
   } decoded_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_ISSUE,
      BK_PTR,
      BK_DATA
   } back_state_type;

endpackage

### rtl/acpu_channels.sv
// Valid/ready channel interfaces for instruction requests and execution results.
interface acpu_req_if;
   logic                                valid;
   logic                                ready;
   logic [3:0]                          operation;
   logic [acpu_pkg::ADDR_BITS-1:0]      address;
   logic signed [acpu_pkg::WORD_BITS-1:0] in_value;

   modport source (output valid, output operation, output address, output in_value,
                   input ready);
   modport sink   (input valid, input operation, input address, input in_value,
                   output ready);
endinterface

interface acpu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [acpu_pkg::WORD_BITS-1:0] acc_value;
   logic [acpu_pkg::ADDR_BITS-1:0]        pc_value;
   logic signed [acpu_pkg::WORD_BITS-1:0] out_value;
   logic                                  out_valid;
   logic                                  halted_flag;

   modport source (output valid, output acc_value, output pc_value, output out_value,
                   output out_valid, output halted_flag, input ready);
   modport sink   (input valid, input acc_value, input pc_value, input out_value,
                   input out_valid, input halted_flag, output ready);
endinterface

### rtl/acpu_front.sv
// Front end: accepts instruction transactions and classifies their memory needs.
module acpu_front (
   acpu_req_if.sink                 req_chan,
   input  acpu_pkg::queue_status_type q_status,
   input  acpu_pkg::back_status_type  bk_status,
   output logic                      push,
   output acpu_pkg::decoded_type     push_data
);
   import acpu_pkg::*;

   opcode_type opcode;

   assign opcode         = opcode_type'(req_chan.operation);
   assign req_chan.ready = !q_status.full && !bk_status.clearing;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      push_data          = '0;
      push_data.opcode   = opcode;
      push_data.address  = req_chan.address;
      push_data.in_value = word_type'(req_chan.in_value);
      unique case (opcode) inside
         OP_LOAD, OP_ADD, OP_SUBT: begin
            push_data.rd_data = 1'b1;
         end
         OP_ADDI, OP_LOADI, OP_SUBTI: begin
            push_data.rd_ptr  = 1'b1;
            push_data.rd_data = 1'b1;
         end
         OP_JUMPI: begin
            push_data.rd_ptr = 1'b1;
         end
         OP_STORE: begin
            push_data.wr_mem = 1'b1;
         end
         OP_STOREI: begin
            push_data.rd_ptr = 1'b1;
            push_data.wr_mem = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/acpu_queue.sv
// Two-entry queue of decoded instructions between the front and back ends.
module acpu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  acpu_pkg::decoded_type      push_data,
   input  logic                       pop,
   output acpu_pkg::decoded_type      head,
   output acpu_pkg::queue_status_type status
);
   import acpu_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   decoded_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/acpu_back.sv
// Back end: sequencer, main memory and architectural registers; drives results.
module acpu_back #(
   parameter int MEM_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  acpu_pkg::decoded_type      head,
   input  acpu_pkg::queue_status_type q_status,
   output logic                       pop,
   output acpu_pkg::back_status_type  status,
   acpu_rsp_if.source                 rsp_chan
);
   import acpu_pkg::*;

   localparam int IDX_BITS  = $clog2(MEM_DEPTH);
   // smallest depth is 16, so the quotient of a 12-bit address has at most this many bits
   localparam int MAX_SHIFT = ADDR_BITS - 4;

   function automatic logic [IDX_BITS-1:0] mem_index(input addr_type a);
      addr_type v;
      v = a;
      for (int k = MAX_SHIFT; k >= 0; k--) begin
         if ((MEM_DEPTH << k) < (1 << ADDR_BITS)) begin
            if (v >= ADDR_BITS'(MEM_DEPTH << k)) begin
               v = v - ADDR_BITS'(MEM_DEPTH << k);
            end
         end
      end
      return v[IDX_BITS-1:0];
   endfunction

   word_type mem [MEM_DEPTH];

   back_state_type      state_ff, state_in;
   logic [IDX_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   word_type            acc_ff, acc_in;
   addr_type            pc_ff, pc_in;
   word_type            outr_ff, outr_in;
   logic                halt_ff, halt_in;
   word_type            mbr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   word_type            rsp_acc_ff;
   addr_type            rsp_pc_ff;
   word_type            rsp_out_ff;
   logic                rsp_flag_ff;
   logic                rsp_halt_ff;

   logic                rd_en;
   logic [IDX_BITS-1:0] rd_idx;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_idx;
   word_type            wr_data;
   logic                finish;
   logic                out_flag;
   logic                slot_free;
   logic                head_valid;
   logic                ac_neg;
   logic                ac_zero;
   logic                take_skip;
   logic [IDX_BITS-1:0] ptr_idx;

   assign slot_free       = !rsp_valid_ff || rsp_chan.ready;
   assign head_valid      = !q_status.empty;
   assign ac_neg          = acc_ff[WORD_BITS-1];
   assign ac_zero         = (acc_ff == '0);
   assign take_skip       = (head.address == SKIP_NEG && ac_neg) ||
                            (head.address == SKIP_ZERO && ac_zero) ||
                            (head.address == SKIP_POS && !ac_neg && !ac_zero);
   assign ptr_idx         = mem_index(mbr_ff[ADDR_BITS-1:0]);
   assign pop             = finish;
   assign status.clearing = (state_ff == BK_CLEAR);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      acc_in     = acc_ff;
      pc_in      = pc_ff;
      outr_in    = outr_ff;
      halt_in    = halt_ff;
      rd_en      = 1'b0;
      rd_idx     = mem_index(head.address);
      wr_en      = 1'b0;
      wr_idx     = mem_index(head.address);
      wr_data    = acc_ff;
      finish     = 1'b0;
      out_flag   = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_cnt_ff;
            wr_data = '0;
            if (clr_cnt_ff == IDX_BITS'(MEM_DEPTH - 1)) begin
               state_in = BK_ISSUE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         BK_ISSUE: begin
            if (head_valid) begin
               if (halt_ff) begin
                  // halted: drop the instruction, still report held state
                  finish = slot_free;
               end else if (head.rd_ptr || head.rd_data) begin
                  rd_en    = 1'b1;
                  state_in = head.rd_ptr ? BK_PTR : BK_DATA;
               end else if (slot_free) begin
                  finish = 1'b1;
                  wr_en  = head.wr_mem;
                  unique case (head.opcode) inside
                     OP_IN:       acc_in = head.in_value;
                     OP_OUT: begin
                        outr_in  = acc_ff;
                        out_flag = 1'b1;
                     end
                     OP_HALT:     halt_in = 1'b1;
                     OP_SKIPCOND: begin
                        if (take_skip) begin
                           pc_in = pc_ff + 1'b1;
                        end
                     end
                     OP_JUMP:     pc_in  = head.address;
                     OP_CLEAR:    acc_in = '0;
                     default: begin
                     end
                  endcase
               end
            end
         end
         BK_PTR: begin
            if (head.rd_data) begin
               rd_en    = 1'b1;
               rd_idx   = ptr_idx;
               state_in = BK_DATA;
            end else if (slot_free) begin
               finish   = 1'b1;
               state_in = BK_ISSUE;
               wr_en    = head.wr_mem;
               wr_idx   = ptr_idx;
               if (head.opcode == OP_JUMPI) begin
                  pc_in = mbr_ff[ADDR_BITS-1:0];
               end
            end
         end
         BK_DATA: begin
            if (slot_free) begin
               finish   = 1'b1;
               state_in = BK_ISSUE;
               unique case (head.opcode) inside
                  OP_LOAD, OP_LOADI: acc_in = mbr_ff;
                  OP_ADD, OP_ADDI:   acc_in = acc_ff + mbr_ff;
                  OP_SUBT, OP_SUBTI: acc_in = acc_ff - mbr_ff;
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_ISSUE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         outr_ff      <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         outr_ff      <= outr_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_acc_ff  <= acc_in;
         rsp_pc_ff   <= pc_in;
         rsp_out_ff  <= outr_in;
         rsp_flag_ff <= out_flag;
         rsp_halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         mbr_ff <= mem[rd_idx];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.acc_value   = rsp_acc_ff;
   assign rsp_chan.pc_value    = rsp_pc_ff;
   assign rsp_chan.out_value   = rsp_out_ff;
   assign rsp_chan.out_valid   = rsp_flag_ff;
   assign rsp_chan.halted_flag = rsp_halt_ff;

endmodule

### rtl/accumulator_cpu_execute.sv
// Sequencing: an instruction without a memory read (store included) finishes in the issue
// state; direct reads, jump indirect and store indirect pass the issue state and then the
// data or pointer state; indirect data reads pass the issue, pointer and data states; the
// back end's single synchronous memory read port sets these steps. An instruction finishes
// only once the response register is free, starts no earlier than the cycle after it is
// accepted, and its result appears the cycle after its last step. Reset: AC, PC, output
// register and halt flag clear; memory is swept to zero after reset, with req_chan.ready low.
module accumulator_cpu_execute #(
   parameter int MEM_DEPTH = 4096
) (
   input logic        clock,
   input logic        reset,
   acpu_req_if.sink   req_chan,
   acpu_rsp_if.source rsp_chan
);
   import acpu_pkg::*;

   logic             push;
   decoded_type      push_data;
   logic             pop;
   decoded_type      head;
   queue_status_type q_status;
   back_status_type  bk_status;

   acpu_front u_front (
      .req_chan  (req_chan),
      .q_status  (q_status),
      .bk_status (bk_status),
      .push      (push),
      .push_data (push_data)
   );

   acpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   acpu_back #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .status   (bk_status),
      .rsp_chan (rsp_chan)
   );

endmodule
